// File: rtl/core/teps_pkg.sv
// Shared constants and register map for the two-element power split.
package teps_pkg;

  localparam int RatingW = 23;
  localparam int AreaW   = 16;
  localparam int FluxW   = 16;
  localparam int DemandW = 24;
  localparam int DutyW   = 17;
  localparam int FluxOutW = 24;

  // flux_limit * total area
  localparam int CapProdN  = 33;
  // Divider dividend widths
  localparam int SplitDivN = 39;  // power * area
  localparam int OutDivN   = 39;  // share << 16, or share * 100

  // cap / 100 as (prod >> 2) * ceil(2^34 / 25) >> 34, exact below 2^31
  localparam int CapRecip  = 687194768;
  localparam int CapShift  = 34;
  // 100 * 2^24: a cap at or above this exceeds any rating sum
  localparam int CapBig    = 1677721600;

  localparam int AreaSumW  = AreaW + 1;

  typedef enum logic [2:0] {
    REG_RATING_ONE = 3'd0,
    REG_RATING_TWO = 3'd1,
    REG_AREA_ONE   = 3'd2,
    REG_AREA_TWO   = 3'd3,
    REG_FLUX_LIMIT = 3'd4
  } reg_idx_t;

endpackage

// File: rtl/core/teps_dly.sv
// Enabled delay line for valid bits and side data that travel beside the dividers.
module teps_dly #(
  parameter int W = 1,
  parameter int L = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] pipe [L+1];

  assign pipe[0] = din;

  for (genvar k = 0; k < L; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[k+1] <= '0;
      end else if (en) begin
        pipe[k+1] <= pipe[k];
      end
    end
  end

  assign dout = pipe[L];

endmodule

// File: rtl/core/teps_div.sv
// Pipelined restoring divider, one quotient bit per stage, MSB first.
module teps_div #(
  parameter int N = 39,
  parameter int D = 17
) (
  input  logic         clk,
  input  logic         en,
  input  logic [N-1:0] num_in,
  input  logic [D-1:0] den_in,
  output logic [N-1:0] quo
);

  // num shifts dividend bits out at the top and quotient bits in at the bottom
  logic [N-1:0] num [N+1];
  logic [D-1:0] rem [N+1];
  logic [D-1:0] den [N+1];

  assign num[0] = num_in;
  assign rem[0] = '0;
  assign den[0] = den_in;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [D:0]   trial;
    logic [D:0]   diff;
    logic         ge;
    logic [D-1:0] rem_next;

    assign trial    = {rem[k], num[k][N-1]};
    assign ge       = trial >= {1'b0, den[k]};
    assign diff     = trial - {1'b0, den[k]};
    assign rem_next = ge ? diff[D-1:0] : trial[D-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        num[k+1] <= {num[k][N-2:0], ge};
        rem[k+1] <= rem_next;
        den[k+1] <= den[k];
      end
    end
  end

  assign quo = num[N];

endmodule

// File: rtl/core/two_element_power_split.sv
// Top level: config registers and the pipelined power split datapath.
//
//  channel | signals                                  | dir
//  --------+------------------------------------------+-----
//  in      | in_valid, in_stall, demand_mw             | in
//  out     | out_valid, out_stall, share/duty/flux x2  | out
//  config  | psel, penable, pwrite, paddr, pwdata,     | in
//          | prdata, pready                           |
//
// One demand per cycle while out_stall does not freeze the pipeline; the path runs
// through two chains of 39 bit-serial divider stages (area split, then duty and
// flux). The flux cap /100 is a reciprocal multiply over two stages.
// Synchronous reset clears config registers and all valid bits.
// The pipeline advances on one global enable; out_stall on a held result
// freezes every stage and raises in_stall.
module two_element_power_split (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [23:0] demand_mw,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [22:0] share_one_mw,
  output logic [22:0] share_two_mw,
  output logic [16:0] duty_one,
  output logic [16:0] duty_two,
  output logic [23:0] flux_one,
  output logic [23:0] flux_two,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW = teps_pkg::RatingW;
  localparam int AW = teps_pkg::AreaW;
  localparam int SW = teps_pkg::AreaSumW;

  // config registers
  logic [RW-1:0] rating_one;
  logic [RW-1:0] rating_two;
  logic [AW-1:0] area_one;
  logic [AW-1:0] area_two;
  logic [teps_pkg::FluxW-1:0] flux_limit;

  teps_pkg::reg_idx_t widx;
  assign widx   = teps_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rating_one <= '0;
      rating_two <= '0;
      area_one   <= '0;
      area_two   <= '0;
      flux_limit <= '0;
    end else if (psel && penable && pwrite) begin
      case (widx)
        teps_pkg::REG_RATING_ONE: rating_one <= pwdata[RW-1:0];
        teps_pkg::REG_RATING_TWO: rating_two <= pwdata[RW-1:0];
        teps_pkg::REG_AREA_ONE:   area_one   <= pwdata[AW-1:0];
        teps_pkg::REG_AREA_TWO:   area_two   <= pwdata[AW-1:0];
        teps_pkg::REG_FLUX_LIMIT: flux_limit <= pwdata[AW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      teps_pkg::REG_RATING_ONE: prdata = {9'b0, rating_one};
      teps_pkg::REG_RATING_TWO: prdata = {9'b0, rating_two};
      teps_pkg::REG_AREA_ONE:   prdata = {16'b0, area_one};
      teps_pkg::REG_AREA_TWO:   prdata = {16'b0, area_two};
      teps_pkg::REG_FLUX_LIMIT: prdata = {16'b0, flux_limit};
      default:                  prdata = '0;
    endcase
  end

  // config-derived values; the user must keep config stable while items are in flight (not enforced by the block)
  logic [SW-1:0] area_sum;
  logic [RW:0]   rating_sum;
  assign area_sum   = {1'b0, area_one} + {1'b0, area_two};
  assign rating_sum = {1'b0, rating_one} + {1'b0, rating_two};

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage 0: capture, negative demand clamps to zero
  logic        s0_vld;
  logic [22:0] s0_p;
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_p <= demand_mw[23] ? '0 : demand_mw[22:0];
    end
  end

  // stage A: flux_limit * total area
  logic                          a_vld;
  logic [22:0]                   a_p;
  logic [teps_pkg::CapProdN-1:0] a_prod;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s0_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_p    <= s0_p;
      a_prod <= {17'b0, flux_limit} * {16'b0, area_sum};
    end
  end

  // stage B: reciprocal multiply for prod / 100; large products only flag
  logic        b_vld;
  logic [22:0] b_p;
  logic        b_big;
  logic [57:0] b_mul;
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_p   <= a_p;
      b_big <= a_prod >= 33'(teps_pkg::CapBig);
      b_mul <= 58'(a_prod[30:2]) * 58'(teps_pkg::CapRecip);
    end
  end

  // stage C: limit and clamp
  logic        c_vld;
  logic [22:0] c_p;
  logic [23:0] b_cap;
  logic        cap_lt;
  logic [23:0] limit;
  assign b_cap  = b_mul[teps_pkg::CapShift+23:teps_pkg::CapShift];
  assign cap_lt = (flux_limit != '0) && !b_big && (b_cap < rating_sum);
  assign limit  = cap_lt ? b_cap : rating_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_p <= ({1'b0, b_p} > limit) ? limit[22:0] : b_p;
    end
  end

  // stage D: power times each area
  logic                           d_vld;
  logic [teps_pkg::SplitDivN-1:0] d_m1;
  logic [teps_pkg::SplitDivN-1:0] d_m2;
  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= c_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_m1 <= {16'b0, c_p} * {23'b0, area_one};
      d_m2 <= {16'b0, c_p} * {23'b0, area_two};
    end
  end

  // stage E: proportional split
  logic [teps_pkg::SplitDivN-1:0] e_q1;
  logic [teps_pkg::SplitDivN-1:0] e_q2;
  logic                           e_vld;

  teps_div #(.N(teps_pkg::SplitDivN), .D(SW)) u_split_div1 (
    .clk (clk), .en (en), .num_in (d_m1), .den_in (area_sum), .quo (e_q1)
  );
  teps_div #(.N(teps_pkg::SplitDivN), .D(SW)) u_split_div2 (
    .clk (clk), .en (en), .num_in (d_m2), .den_in (area_sum), .quo (e_q2)
  );
  teps_dly #(.W(1), .L(teps_pkg::SplitDivN)) u_split_dly (
    .clk (clk), .rst (rst), .en (en), .din (d_vld), .dout (e_vld)
  );

  // stage F: move overflow across, then clamp both
  logic        f_vld;
  logic [22:0] f_x1;
  logic [22:0] f_x2;
  logic [23:0] t1;
  logic [23:0] t2;
  logic [23:0] r1e;
  logic [23:0] r2e;
  logic        all_zero;

  assign r1e      = {1'b0, rating_one};
  assign r2e      = {1'b0, rating_two};
  assign all_zero = (area_sum == '0) || ((rating_one == '0) && (rating_two == '0));

  always_comb begin
    t1 = e_q1[23:0];
    t2 = e_q2[23:0];
    if (t1 > r1e) begin
      t2 = t2 + (t1 - r1e);
      t1 = r1e;
    end
    if (t2 > r2e) begin
      t1 = t1 + (t2 - r2e);
      t2 = r2e;
    end
    if (t1 > r1e) begin
      t1 = r1e;
    end
    if (t2 > r2e) begin
      t2 = r2e;
    end
    if (all_zero) begin
      t1 = '0;
      t2 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= e_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_x1 <= t1[22:0];
      f_x2 <= t2[22:0];
    end
  end

  // stage G: dividends for duty (Q16) and flux (x100)
  logic                         g_vld;
  logic [22:0]                  g_x1;
  logic [22:0]                  g_x2;
  logic [teps_pkg::OutDivN-1:0] g_d1;
  logic [teps_pkg::OutDivN-1:0] g_d2;
  logic [teps_pkg::OutDivN-1:0] g_f1;
  logic [teps_pkg::OutDivN-1:0] g_f2;
  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (en) begin
      g_vld <= f_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      g_x1 <= f_x1;
      g_x2 <= f_x2;
      g_d1 <= {f_x1, 16'b0};
      g_d2 <= {f_x2, 16'b0};
      g_f1 <= {9'b0, 30'({7'b0, f_x1} * 30'd100)};
      g_f2 <= {9'b0, 30'({7'b0, f_x2} * 30'd100)};
    end
  end

  // stage H: duty and flux divisions
  logic [teps_pkg::OutDivN-1:0] h_d1;
  logic [teps_pkg::OutDivN-1:0] h_d2;
  logic [teps_pkg::OutDivN-1:0] h_f1;
  logic [teps_pkg::OutDivN-1:0] h_f2;
  logic                         h_vld;
  logic [22:0]                  h_x1;
  logic [22:0]                  h_x2;

  teps_div #(.N(teps_pkg::OutDivN), .D(RW)) u_duty_div1 (
    .clk (clk), .en (en), .num_in (g_d1), .den_in (rating_one), .quo (h_d1)
  );
  teps_div #(.N(teps_pkg::OutDivN), .D(RW)) u_duty_div2 (
    .clk (clk), .en (en), .num_in (g_d2), .den_in (rating_two), .quo (h_d2)
  );
  teps_div #(.N(teps_pkg::OutDivN), .D(AW)) u_flux_div1 (
    .clk (clk), .en (en), .num_in (g_f1), .den_in (area_one), .quo (h_f1)
  );
  teps_div #(.N(teps_pkg::OutDivN), .D(AW)) u_flux_div2 (
    .clk (clk), .en (en), .num_in (g_f2), .den_in (area_two), .quo (h_f2)
  );
  teps_dly #(.W(47), .L(teps_pkg::OutDivN)) u_out_dly (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  ({g_vld, g_x1, g_x2}),
    .dout ({h_vld, h_x1, h_x2})
  );

  // stage I: output register, zero divisors and flux saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= h_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      share_one_mw <= h_x1;
      share_two_mw <= h_x2;
      duty_one     <= (rating_one == '0) ? '0 : h_d1[16:0];
      duty_two     <= (rating_two == '0) ? '0 : h_d2[16:0];
      flux_one     <= (area_one == '0) ? '0 :
                      ((|h_f1[38:24]) ? 24'hFFFFFF : h_f1[23:0]);
      flux_two     <= (area_two == '0) ? '0 :
                      ((|h_f2[38:24]) ? 24'hFFFFFF : h_f2[23:0]);
    end
  end

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_one <= 17'd65536) && (duty_two <= 17'd65536))
    else $error("duty above full scale");

  a_share_rating: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (share_one_mw <= rating_one) && (share_two_mw <= rating_two))
    else $error("share above rating");

  a_hold_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result held");

endmodule
